// ----- rtl/core/bpsm_pkg.sv -----
// bpsm_pkg: shared types and constants of the brake pressure sensor monitor
// no dependencies; used by the interfaces and by every module of the block but bpsm_mac
package bpsm_pkg;

  // fixed field widths
  localparam int ALPHA_W     = 17;
  localparam int THR_W       = 12;
  localparam int TICK_W      = 32;
  localparam int GAIN_W      = 24;
  localparam int OFFSET_W    = 16;
  localparam int PSI_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // fixed-point scaling of alpha (Q1.16) and of the gain (Q8.16)
  localparam int ALPHA_SHIFT = 16;
  localparam int GAIN_FRAC   = 16;

  // saturation bounds of the pressure outputs
  localparam int PSI_MAX     = 32767;
  localparam int PSI_MIN     = -32768;

  // reset values of the configuration registers
  localparam logic [ALPHA_W-1:0]         ALPHA_RST  = 17'd26214;
  localparam logic [THR_W-1:0]           LOW_RST    = 12'd205;
  localparam logic [THR_W-1:0]           HIGH_RST   = 12'd3890;
  localparam logic [TICK_W-1:0]          LIMIT_RST  = 32'd100;
  localparam logic [GAIN_W-1:0]          GAIN_RST   = 24'd65536;
  localparam logic signed [OFFSET_W-1:0] OFFSET_RST = 16'sd0;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA  = 3'd0,
    REG_LOW    = 3'd1,
    REG_HIGH   = 3'd2,
    REG_LIMIT  = 3'd3,
    REG_GAIN   = 3'd4,
    REG_OFFSET = 3'd5
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_UPDATE,
    ST_PSI_LO,
    ST_PSI_HI,
    ST_PSI,
    ST_DONE
  } seq_state_e;

  // configuration register contents
  typedef struct packed {
    logic [ALPHA_W-1:0]         alpha;
    logic [THR_W-1:0]           low;
    logic [THR_W-1:0]           high;
    logic [TICK_W-1:0]          limit;
    logic [GAIN_W-1:0]          gain;
    logic signed [OFFSET_W-1:0] offset;
  } cfg_t;

  // sequencer strobes towards the datapath
  typedef struct packed {
    logic in_ready;
    logic ch;
    logic do_diff;
    logic do_mul_lo;
    logic do_mul_hi;
    logic do_update;
    logic do_psi_lo;
    logic do_psi_hi;
    logic do_psi;
    logic out_load;
  } ctrl_t;

endpackage

// ----- rtl/core/bpsm_in_if.sv -----
// bpsm_in_if: input channel, one pair of adc samples and the tick count per item
// depends on bpsm_pkg
interface bpsm_in_if #(
  parameter int ADC_BITS = 12
);
  logic                          valid;
  logic                          ready;
  logic [ADC_BITS-1:0]           front_sample;
  logic [ADC_BITS-1:0]           rear_sample;
  logic [bpsm_pkg::TICK_W-1:0]   now_tick;

  modport source (output valid, output front_sample, output rear_sample,
                  output now_tick, input ready);
  modport sink   (input valid, input front_sample, input rear_sample,
                  input now_tick, output ready);
endinterface

// ----- rtl/core/bpsm_out_if.sv -----
// bpsm_out_if: result channel, two pressures and the fault flag per item
// depends on bpsm_pkg
interface bpsm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [bpsm_pkg::PSI_W-1:0]  front_psi;
  logic signed [bpsm_pkg::PSI_W-1:0]  rear_psi;
  logic                               sensor_fault;

  modport source (output valid, output front_psi, output rear_psi,
                  output sensor_fault, input ready);
  modport sink   (input valid, input front_psi, input rear_psi,
                  input sensor_fault, output ready);
endinterface

// ----- rtl/core/bpsm_cfg_if.sv -----
// bpsm_cfg_if: configuration write channel, register index and write data
// depends on bpsm_pkg
interface bpsm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bpsm_pkg::CFG_IDX_W-1:0]    index;
  logic [bpsm_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/bpsm_cfg.sv -----
// bpsm_cfg: configuration register bank of the brake pressure sensor monitor
// depends on bpsm_pkg and bpsm_cfg_if
module bpsm_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  bpsm_cfg_if.sink           cfg_i,
  output bpsm_pkg::cfg_t     cfg_o
);

  bpsm_pkg::cfg_t cfg_q;

  // writes always taken
  assign cfg_i.ready = 1'b1;

  // register write, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha  <= bpsm_pkg::ALPHA_RST;
      cfg_q.low    <= bpsm_pkg::LOW_RST;
      cfg_q.high   <= bpsm_pkg::HIGH_RST;
      cfg_q.limit  <= bpsm_pkg::LIMIT_RST;
      cfg_q.gain   <= bpsm_pkg::GAIN_RST;
      cfg_q.offset <= bpsm_pkg::OFFSET_RST;
    end else if (cfg_i.valid) begin
      case (bpsm_pkg::cfg_idx_e'(cfg_i.index))
        bpsm_pkg::REG_ALPHA:  cfg_q.alpha  <= cfg_i.data[bpsm_pkg::ALPHA_W-1:0];
        bpsm_pkg::REG_LOW:    cfg_q.low    <= cfg_i.data[bpsm_pkg::THR_W-1:0];
        bpsm_pkg::REG_HIGH:   cfg_q.high   <= cfg_i.data[bpsm_pkg::THR_W-1:0];
        bpsm_pkg::REG_LIMIT:  cfg_q.limit  <= cfg_i.data[bpsm_pkg::TICK_W-1:0];
        bpsm_pkg::REG_GAIN:   cfg_q.gain   <= cfg_i.data[bpsm_pkg::GAIN_W-1:0];
        bpsm_pkg::REG_OFFSET: cfg_q.offset <= $signed(cfg_i.data[bpsm_pkg::OFFSET_W-1:0]);
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/bpsm_mac.sv -----
// bpsm_mac: shared multiply-accumulate unit, one partial product per cycle
// no package dependency; widths come from the instantiating module
module bpsm_mac #(
  parameter int A_W   = 14,
  parameter int B_W   = 24,
  parameter int ACC_W = 52
) (
  input  logic [A_W-1:0]   a_i,
  input  logic [B_W-1:0]   b_i,
  input  logic [ACC_W-1:0] acc_i,
  input  logic             hi_i,
  output logic [ACC_W-1:0] acc_o
);

  logic [A_W+B_W-1:0] prod;
  logic [ACC_W-1:0]   prod_ext;

  // low half starts a fresh sum, high half is added one half-width up
  assign prod     = a_i * b_i;
  assign prod_ext = ACC_W'(prod);
  assign acc_o    = hi_i ? (acc_i + (prod_ext << A_W)) : prod_ext;

endmodule

// ----- rtl/core/bpsm_seq.sv -----
// bpsm_seq: sequencer stepping both channels through the shared mac unit
// depends on bpsm_pkg
module bpsm_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             out_busy_i,
  output bpsm_pkg::ctrl_t  ctrl_o
);

  bpsm_pkg::seq_state_e state_q, state_d;
  logic                 ch_q, ch_d;

  // state and channel registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpsm_pkg::ST_IDLE;
      ch_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
    end
  end

  // next state and strobes
  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    ctrl_o  = '0;
    ctrl_o.ch = ch_q;
    case (state_q)
      bpsm_pkg::ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        ch_d = 1'b0;
        if (in_valid_i) state_d = bpsm_pkg::ST_DIFF;
      end
      bpsm_pkg::ST_DIFF: begin
        ctrl_o.do_diff = 1'b1;
        state_d = bpsm_pkg::ST_MUL_LO;
      end
      bpsm_pkg::ST_MUL_LO: begin
        ctrl_o.do_mul_lo = 1'b1;
        state_d = bpsm_pkg::ST_MUL_HI;
      end
      bpsm_pkg::ST_MUL_HI: begin
        ctrl_o.do_mul_hi = 1'b1;
        state_d = bpsm_pkg::ST_UPDATE;
      end
      bpsm_pkg::ST_UPDATE: begin
        ctrl_o.do_update = 1'b1;
        state_d = bpsm_pkg::ST_PSI_LO;
      end
      bpsm_pkg::ST_PSI_LO: begin
        ctrl_o.do_psi_lo = 1'b1;
        state_d = bpsm_pkg::ST_PSI_HI;
      end
      bpsm_pkg::ST_PSI_HI: begin
        ctrl_o.do_psi_hi = 1'b1;
        state_d = bpsm_pkg::ST_PSI;
      end
      bpsm_pkg::ST_PSI: begin
        ctrl_o.do_psi = 1'b1;
        if (ch_q) begin
          state_d = bpsm_pkg::ST_DONE;
        end else begin
          ch_d    = 1'b1;
          state_d = bpsm_pkg::ST_DIFF;
        end
      end
      bpsm_pkg::ST_DONE: begin
        // wait for a free output slot
        if (!out_busy_i) begin
          ctrl_o.out_load = 1'b1;
          state_d = bpsm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bpsm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/brake_pressure_sensor_monitor_top.sv -----
// brake_pressure_sensor_monitor_top: low-pass filters, range fault timer, psi scaling
// depends on bpsm_pkg, the bpsm interfaces, bpsm_cfg, bpsm_mac and bpsm_seq
// flow: an accepted item steps through both channels, then waits in ST_DONE for a free output slot
// a new item is taken only in ST_IDLE, after the last result is loaded; each channel takes seven steps of the sequencer
//   and both share one multiply-accumulate unit, two partial products per multiplication
// reset: filter states, last healthy tick and fault flag clear, registers take defaults
module brake_pressure_sensor_monitor_top #(
  parameter int ADC_BITS  = 12,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bpsm_in_if.sink     in_i,
  bpsm_out_if.source  out_o,
  bpsm_cfg_if.sink    cfg_i
);

  localparam int STATE_W  = ADC_BITS + FRAC_BITS;
  localparam int HALF_W   = (STATE_W + 1) / 2;
  localparam int ACC_W    = STATE_W + bpsm_pkg::GAIN_W;
  localparam int STEP_W   = ACC_W - bpsm_pkg::ALPHA_SHIFT;
  localparam int PSI_SH   = FRAC_BITS + bpsm_pkg::GAIN_FRAC;
  localparam int SCALED_W = ACC_W - PSI_SH;
  localparam int SUM_W    = SCALED_W + 2;
  localparam int CMP_W    = (ADC_BITS > bpsm_pkg::THR_W) ? ADC_BITS : bpsm_pkg::THR_W;
  localparam logic [STATE_W-1:0] STATE_MAX = '1;

  bpsm_pkg::cfg_t   cfg;
  bpsm_pkg::ctrl_t  ctrl;

  logic [ADC_BITS-1:0]               front_q, rear_q;
  logic [bpsm_pkg::TICK_W-1:0]       now_q;
  logic [STATE_W-1:0]                filt_q [2];
  logic [bpsm_pkg::TICK_W-1:0]       last_q;
  logic                              fault_q, fault_d;
  logic                              neg_q;
  logic [STATE_W-1:0]                mag_q;
  logic [ACC_W-1:0]                  acc_q, acc_d;
  logic signed [bpsm_pkg::PSI_W-1:0] psi_q [2];
  logic                              out_valid_q;
  logic signed [bpsm_pkg::PSI_W-1:0] out_front_q, out_rear_q;

  logic                              in_acc, out_busy;
  logic [ADC_BITS-1:0]               samp;
  logic [STATE_W-1:0]                cur, target, filt_upd;
  logic [STEP_W-1:0]                 step;
  logic [ACC_W-1:0]                  sum;
  logic [HALF_W-1:0]                 mac_a;
  logic [bpsm_pkg::GAIN_W-1:0]       mac_b;
  logic                              mac_hi;
  logic [SCALED_W-1:0]               scaled;
  logic signed [SUM_W-1:0]           psi_sum;
  logic signed [bpsm_pkg::PSI_W-1:0] psi_sat;
  logic [CMP_W-1:0]                  cnt_f, cnt_r, thr_lo, thr_hi;
  logic                              win_both;
  logic [bpsm_pkg::TICK_W-1:0]       elapsed;

  bpsm_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign out_busy = out_valid_q && !out_o.ready;

  bpsm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .out_busy_i (out_busy),
    .ctrl_o     (ctrl)
  );

  assign in_i.ready = ctrl.in_ready;
  assign in_acc     = in_i.valid && ctrl.in_ready;

  // input item capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      front_q <= in_i.front_sample;
      rear_q  <= in_i.rear_sample;
      now_q   <= in_i.now_tick;
    end
  end

  // current channel and its aligned target
  assign cur    = filt_q[ctrl.ch];
  assign samp   = ctrl.ch ? rear_q : front_q;
  assign target = {samp, {FRAC_BITS{1'b0}}};

  // difference magnitude and direction
  always_ff @(posedge clk_i) begin
    if (ctrl.do_diff) begin
      neg_q <= (target < cur);
      mag_q <= (target < cur) ? (cur - target) : (target - cur);
    end
  end

  // operand selection for the shared mac unit
  always_comb begin
    mac_a  = mag_q[HALF_W-1:0];
    mac_b  = bpsm_pkg::GAIN_W'(cfg.alpha);
    mac_hi = ctrl.do_mul_hi || ctrl.do_psi_hi;
    if (ctrl.do_mul_hi) begin
      mac_a = HALF_W'(mag_q[STATE_W-1:HALF_W]);
    end else if (ctrl.do_psi_lo) begin
      mac_a = cur[HALF_W-1:0];
      mac_b = cfg.gain;
    end else if (ctrl.do_psi_hi) begin
      mac_a = HALF_W'(cur[STATE_W-1:HALF_W]);
      mac_b = cfg.gain;
    end
  end

  bpsm_mac #(
    .A_W   (HALF_W),
    .B_W   (bpsm_pkg::GAIN_W),
    .ACC_W (ACC_W)
  ) u_mac (
    .a_i   (mac_a),
    .b_i   (mac_b),
    .acc_i (acc_q),
    .hi_i  (mac_hi),
    .acc_o (acc_d)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl.do_mul_lo || ctrl.do_mul_hi || ctrl.do_psi_lo || ctrl.do_psi_hi) begin
      acc_q <= acc_d;
    end
  end

  // filter update with saturation at both ends
  assign step = acc_q[ACC_W-1:bpsm_pkg::ALPHA_SHIFT];
  assign sum  = ACC_W'(cur) + ACC_W'(step);

  always_comb begin
    if (!neg_q) begin
      filt_upd = (sum > ACC_W'(STATE_MAX)) ? STATE_MAX : sum[STATE_W-1:0];
    end else begin
      filt_upd = (ACC_W'(step) > ACC_W'(cur)) ? '0 : (cur - step[STATE_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q[0] <= '0;
      filt_q[1] <= '0;
    end else if (ctrl.do_update) begin
      filt_q[ctrl.ch] <= filt_upd;
    end
  end

  // pressure scaling, offset and saturation
  assign scaled  = acc_q[ACC_W-1:PSI_SH];
  assign psi_sum = $signed({2'b00, scaled}) + SUM_W'(cfg.offset);

  always_comb begin
    if (psi_sum > SUM_W'(bpsm_pkg::PSI_MAX)) begin
      psi_sat = bpsm_pkg::PSI_W'(bpsm_pkg::PSI_MAX);
    end else if (psi_sum < SUM_W'(bpsm_pkg::PSI_MIN)) begin
      psi_sat = bpsm_pkg::PSI_W'(bpsm_pkg::PSI_MIN);
    end else begin
      psi_sat = psi_sum[bpsm_pkg::PSI_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.do_psi) begin
      psi_q[ctrl.ch] <= psi_sat;
    end
  end

  // plausibility window on the integer parts
  assign cnt_f    = CMP_W'(filt_q[0][STATE_W-1:FRAC_BITS]);
  assign cnt_r    = CMP_W'(filt_q[1][STATE_W-1:FRAC_BITS]);
  assign thr_lo   = CMP_W'(cfg.low);
  assign thr_hi   = CMP_W'(cfg.high);
  assign win_both = (cnt_f >= thr_lo) && (cnt_f <= thr_hi) &&
                    (cnt_r >= thr_lo) && (cnt_r <= thr_hi);
  assign elapsed  = now_q - last_q;

  always_comb begin
    fault_d = fault_q;
    if (win_both) begin
      fault_d = 1'b0;
    end else if (elapsed > cfg.limit) begin
      fault_d = 1'b1;
    end
  end

  // fault timer state, updated as the result is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      fault_q <= 1'b0;
    end else if (ctrl.out_load) begin
      fault_q <= fault_d;
      if (win_both) last_q <= now_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_front_q <= psi_q[0];
      out_rear_q  <= psi_q[1];
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.front_psi    = out_front_q;
  assign out_o.rear_psi     = out_rear_q;
  assign out_o.sensor_fault = fault_q;

  // no second item taken while one is in the sequencer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("input taken again while an item is in progress");

  // a result is never loaded over one that waits
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> !out_busy)
    else $error("result loaded over a pending result");

  // a loaded result is offered in the next cycle
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |=> out_valid_q)
    else $error("loaded result not offered");

  // the fault only rises on a load with a value out of the window
  a_fault_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fault_q) |-> $past(ctrl.out_load && !win_both))
    else $error("fault set without an out-of-window value");

endmodule
